// ===== hdl/segment_locator_for_peak_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Segment locator assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_LOCATOR_FOR_PEAK_UNIT_MACROS_SVH
`define SEGMENT_LOCATOR_FOR_PEAK_UNIT_MACROS_SVH

// same-cycle implication
`define SLFP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment locator check failed");

// next-cycle implication
`define SLFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment locator check failed");

`endif

// ===== hdl/slfp_pkg.sv =====
// ---------------------------------------------------------------------------
// slfp_pkg
// Widths, codes and controller/datapath interface types of the segment
// locator.
// ---------------------------------------------------------------------------
`default_nettype none

package slfp_pkg;

   localparam int MAX_BOUNDARIES = 256;
   localparam int POS_BITS       = 24;
   localparam int IDX_BITS       = $clog2(MAX_BOUNDARIES);
   localparam int CNT_BITS       = IDX_BITS + 1;

   localparam int NUM_BITS       = 9;
   localparam int HOP_BITS       = 20;
   localparam int HOP_FRAC       = 8;
   localparam int FRAME_BITS     = 16;
   localparam int SLOT_BITS      = 8;
   localparam int SEG_BITS       = 9;
   localparam int PROD_BITS      = FRAME_BITS + HOP_BITS;

   localparam logic [63:0] POS_MAX = (64'd1 << POS_BITS) - 64'd1;

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [HOP_BITS-1:0] HOP_RESET = HOP_BITS'(256);

   // register index = paddr[2]
   typedef enum logic {
      REG_NUM_BOUNDARIES = 1'b0,
      REG_HOP_Q8         = 1'b1
   } reg_idx_type;

   // op field codes
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_LOCATE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_LAST,
      RD_FIRST,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_NOT_FOUND,
      RES_BEFORE_FIRST,
      RES_INTERVAL
   } res_sel_type;

   typedef struct packed {
      logic        wr_entry;
      logic        load_frame;
      logic        do_mul;
      logic        do_sat;
      rd_sel_type  rd_sel;
      logic        shift;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic pos_ge_data;
      logic pos_lt_data;
      logic hit;
      logic scan_end;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/slfp_csr.sv =====
// ---------------------------------------------------------------------------
// slfp_csr
// APB register file: boundary count and hop size.
// ---------------------------------------------------------------------------
`default_nettype none

module slfp_csr
   import slfp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output logic      [NUM_BITS-1:0]      num_boundaries,
   output logic      [HOP_BITS-1:0]      hop_q8
);

   logic [NUM_BITS-1:0] num_ff;
   logic [NUM_BITS-1:0] num_in;
   logic [HOP_BITS-1:0] hop_ff;
   logic [HOP_BITS-1:0] hop_in;
   logic                wr_en;
   reg_idx_type         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[2]);

   always_comb begin
      num_in = num_ff;
      hop_in = hop_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_NUM_BOUNDARIES: num_in = pwdata[NUM_BITS-1:0];
            REG_HOP_Q8:         hop_in = pwdata[HOP_BITS-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_NUM_BOUNDARIES: prdata = CSR_DATA_BITS'(num_ff);
         REG_HOP_Q8:         prdata = CSR_DATA_BITS'(hop_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         hop_ff <= HOP_RESET;
      end else begin
         num_ff <= num_in;
         hop_ff <= hop_in;
      end
   end

   assign num_boundaries = num_ff;
   assign hop_q8         = hop_ff;

endmodule

`default_nettype wire

// ===== hdl/slfp_dp.sv =====
// ---------------------------------------------------------------------------
// slfp_dp
// Datapath: boundary memory, frame scaling, scan registers and result
// registers.
// ---------------------------------------------------------------------------
`default_nettype none

module slfp_dp
   import slfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic [SLOT_BITS-1:0]  slot,
   input  wire logic [POS_BITS-1:0]   boundary_value,
   input  wire logic [FRAME_BITS-1:0] frame_index,
   input  wire logic [NUM_BITS-1:0]   num_boundaries,
   input  wire logic [HOP_BITS-1:0]   hop_q8,
   output logic                       status,
   output logic      [SEG_BITS-1:0]   segment_number,
   output logic      [POS_BITS-1:0]   segment_start,
   output logic      [POS_BITS-1:0]   segment_end
);

   logic [POS_BITS-1:0]   mem [MAX_BOUNDARIES];

   logic [FRAME_BITS-1:0] frame_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [POS_BITS-1:0]   pos_in;
   logic [POS_BITS-1:0]   rd_data_ff;
   logic [CNT_BITS-1:0]   idx_ff;
   logic [CNT_BITS-1:0]   idx_in;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  rd_en;
   logic [POS_BITS-1:0]   prev_ff;
   logic [POS_BITS-1:0]   pprev_ff;
   logic                  status_ff;
   logic [SEG_BITS-1:0]   seg_ff;
   logic [POS_BITS-1:0]   start_ff;
   logic [POS_BITS-1:0]   end_ff;
   logic [CNT_BITS-1:0]   n_eff;
   logic [63:0]           scaled;
   logic                  slot_ok;
   logic                  on_inner;

   // count clamped to table depth
   assign n_eff = (32'(num_boundaries) > MAX_BOUNDARIES) ? CNT_BITS'(MAX_BOUNDARIES)
                                                         : CNT_BITS'(num_boundaries);

   assign slot_ok = 32'(slot) < MAX_BOUNDARIES;

   // saturate the Q8 product down to a sample position
   assign scaled = 64'(prod_ff >> HOP_FRAC);
   assign pos_in = (scaled > POS_MAX) ? POS_BITS'(POS_MAX) : scaled[POS_BITS-1:0];

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = idx_ff[IDX_BITS-1:0];
      idx_in  = idx_ff;
      case (cmd.rd_sel)
         RD_LAST:  rd_addr = IDX_BITS'(n_eff - CNT_BITS'(1));
         RD_FIRST: begin
            rd_addr = '0;
            idx_in  = CNT_BITS'(1);
         end
         RD_NEXT:  idx_in = idx_ff + CNT_BITS'(1);
         default:  rd_en = 1'b0;
      endcase
   end

   // data index in scan is idx_ff-1; prev_ff holds the entry below it
   assign stat.n_zero      = (n_eff == '0);
   assign stat.pos_ge_data = (pos_ff >= rd_data_ff);
   assign stat.pos_lt_data = (pos_ff < rd_data_ff);
   assign stat.hit         = (prev_ff <= pos_ff) && (pos_ff < rd_data_ff);
   assign stat.scan_end    = (idx_ff == n_eff);

   // equal to an inner boundary (not boundary 0)
   assign on_inner = (prev_ff == pos_ff) && (idx_ff != CNT_BITS'(2));

   always_ff @(posedge clock) begin
      if (cmd.wr_entry && slot_ok) begin
         mem[IDX_BITS'(slot)] <= boundary_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_frame) begin
         frame_ff <= frame_index;
      end
      if (cmd.do_mul) begin
         prod_ff <= PROD_BITS'(frame_ff) * PROD_BITS'(hop_q8);
      end
      if (cmd.do_sat) begin
         pos_ff <= pos_in;
      end
      if (cmd.shift) begin
         pprev_ff <= prev_ff;
         prev_ff  <= rd_data_ff;
      end
      case (cmd.res_sel)
         RES_NOT_FOUND: begin
            status_ff <= 1'b1;
            seg_ff    <= '0;
            start_ff  <= '0;
            end_ff    <= '0;
         end
         RES_BEFORE_FIRST: begin
            status_ff <= 1'b0;
            seg_ff    <= '0;
            start_ff  <= POS_BITS'(1);
            end_ff    <= rd_data_ff;
         end
         RES_INTERVAL: begin
            status_ff <= 1'b0;
            end_ff    <= rd_data_ff;
            if (on_inner) begin
               seg_ff   <= SEG_BITS'(idx_ff - CNT_BITS'(2));
               start_ff <= pprev_ff;
            end else begin
               seg_ff   <= SEG_BITS'(idx_ff - CNT_BITS'(1));
               start_ff <= prev_ff;
            end
         end
         default: ;
      endcase
   end

   assign status         = status_ff;
   assign segment_number = seg_ff;
   assign segment_start  = start_ff;
   assign segment_end    = end_ff;

endmodule

`default_nettype wire

// ===== hdl/slfp_ctrl.sv =====
// ---------------------------------------------------------------------------
// slfp_ctrl
// Sequencer: accepts items, steps the datapath through scale, end checks
// and the boundary scan, and strobes the result.
// ---------------------------------------------------------------------------
`default_nettype none

module slfp_ctrl
   import slfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     op,
   output logic          busy,
   output logic          done,
   output cmd_type       cmd,
   input  wire stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_LAST,
      ST_FIRST,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      done_ff;
   logic      done_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cmd      = '{wr_entry: 1'b0, load_frame: 1'b0, do_mul: 1'b0, do_sat: 1'b0,
                   rd_sel: RD_NONE, shift: 1'b0, res_sel: RES_NONE};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(op) == OP_LOCATE) begin
                  cmd.load_frame = 1'b1;
                  state_in       = ST_MUL;
               end else begin
                  cmd.wr_entry = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            cmd.do_sat = 1'b1;
            if (stat.n_zero) begin
               cmd.res_sel = RES_NOT_FOUND;
               done_in     = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.rd_sel = RD_LAST;
               state_in   = ST_LAST;
            end
         end
         ST_LAST: begin
            if (stat.pos_ge_data) begin
               cmd.res_sel = RES_NOT_FOUND;
               done_in     = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.rd_sel = RD_FIRST;
               state_in   = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (stat.pos_lt_data) begin
               cmd.res_sel = RES_BEFORE_FIRST;
               done_in     = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.shift  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.res_sel = RES_INTERVAL;
               done_in     = 1'b1;
               state_in    = ST_IDLE;
            end else if (stat.scan_end) begin
               cmd.res_sel = RES_NOT_FOUND;
               done_in     = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.shift  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = done_ff;

endmodule

`default_nettype wire

// ===== hdl/segment_locator_for_peak_unit.sv =====
// ---------------------------------------------------------------------------
// segment_locator_for_peak_unit
// Finds the segment of a boundary table that holds a peak's sample position.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load item (op 0)
// writes one boundary into the table in that same cycle and never produces a
// result; busy stays low, so loads can go back to back. A locate item (op 1)
// holds busy high while it does the frame*hop multiply, saturates the
// position, checks the last and first boundaries, then scans the table at
// one entry per cycle through the single read port of the boundary memory,
// over the first n entries, n being the boundary count clamped to 256.
// The result appears for exactly one cycle on rsp_* with rsp_valid high, in
// the same cycle in which busy drops. The receiver cannot stall: it must take
// the item in that cycle. A new item may be started in the strobe cycle.
// Table entries below the boundary count must have been loaded before a
// locate; the table is not cleared at reset. Registers at byte address 0
// (boundary count) and 4 (hop, Q12.8) may only be written while idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segment_locator_for_peak_unit_macros.svh"

module segment_locator_for_peak_unit
   import slfp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   // item channel
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_op,
   input  wire logic [SLOT_BITS-1:0]     req_slot,
   input  wire logic [POS_BITS-1:0]      req_boundary_value,
   input  wire logic [FRAME_BITS-1:0]    req_frame_index,

   // result channel, one-cycle strobe
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic      [SEG_BITS-1:0]      rsp_segment_number,
   output logic      [POS_BITS-1:0]      rsp_segment_start,
   output logic      [POS_BITS-1:0]      rsp_segment_end,

   // register port
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cmd_type             cmd;
   stat_type            stat;
   logic [NUM_BITS-1:0] num_boundaries;
   logic [HOP_BITS-1:0] hop_q8;

   slfp_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .num_boundaries (num_boundaries),
      .hop_q8         (hop_q8)
   );

   // sequencer: owns accept, busy and the result strobe
   slfp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .busy  (busy),
      .done  (rsp_valid),
      .cmd   (cmd),
      .stat  (stat)
   );

   // table memory, scale, compares and result registers
   slfp_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .stat           (stat),
      .slot           (req_slot),
      .boundary_value (req_boundary_value),
      .frame_index    (req_frame_index),
      .num_boundaries (num_boundaries),
      .hop_q8         (hop_q8),
      .status         (rsp_status),
      .segment_number (rsp_segment_number),
      .segment_start  (rsp_segment_start),
      .segment_end    (rsp_segment_end)
   );

   // strobe only shows up once the sequencer is back at rest
   `SLFP_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_valid, !busy)
   // strobe lasts a single cycle
   `SLFP_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid)
   // a load never produces a result
   `SLFP_ASSERT_NEXT(a_load_silent, clock, reset,
      start && !busy && !req_op, !rsp_valid && !busy)
   // a locate always occupies the sequencer
   `SLFP_ASSERT_NEXT(a_locate_busy, clock, reset, start && !busy && req_op, busy)
   // not-found results carry all-zero payload
   `SLFP_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && rsp_status,
      rsp_segment_number == '0 && rsp_segment_start == '0 && rsp_segment_end == '0)

endmodule

`default_nettype wire
